>>> sv/tbbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbe_pkg
// Shared constants, request codes and types of the three-band equaliser.
// ----------------------------------------------------------------------------
package tbbe_pkg;

    // parameter defaults
    localparam int DEF_CHANNEL_SETS = 2;
    localparam int DEF_SAMPLE_BITS  = 24;
    localparam int DEF_COEF_BITS    = 32;

    // filter structure
    localparam int BAND_COUNT     = 3;
    localparam int TOPOLOGY_COUNT = 3;
    localparam int MIX_COUNT      = BAND_COUNT * TOPOLOGY_COUNT;
    localparam int COEF_TAPS      = 5;
    localparam int COEF_COUNT     = MIX_COUNT * COEF_TAPS;
    localparam int MIX_IDX_W      = 4;
    localparam int COEF_IDX_W     = 6;
    localparam int CH_W           = 3;
    localparam int MODE_W         = 2;

    // number formats
    localparam int DELAY_W     = 40;
    localparam int WEIGHT_FRAC = 17;
    localparam int WEIGHT_W    = 18;
    localparam int STEP_W      = 19;
    localparam int GAIN_FRAC   = 20;
    localparam int GAIN_W      = 24;
    localparam int RAMP_W      = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FRAC);

    // configuration registers
    localparam logic       CFG_RAMP_STEPS  = 1'b0;
    localparam logic       CFG_OUTPUT_GAIN = 1'b1;
    localparam logic [RAMP_W-1:0] RAMP_RESET = 16'd960;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h100000;

    // request types
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_COEF   = 2'd1;
    localparam logic [1:0] REQ_MODE   = 2'd2;

    // outer band topologies
    localparam logic [MODE_W-1:0] MODE_PASS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD  = 2'd3;

    // request to the weight unit
    typedef struct packed {
        logic              advance;
        logic              set_modes;
        logic [MODE_W-1:0] low_mode;
        logic [MODE_W-1:0] high_mode;
    } t_wgt_req;

endpackage

>>> sv/tbbe_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbe_weights
// Crossfade weights of the nine sections: frame ramp, mode targets and a
// bit-serial divider that works out each ramp step.
// ----------------------------------------------------------------------------
module tbbe_weights import tbbe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_wgt_req             i_req,
    input  logic [RAMP_W-1:0]    i_ramp_steps,
    input  logic [MIX_IDX_W-1:0] i_rd_idx,
    output logic [WEIGHT_W-1:0]  o_rd_weight,
    output logic                 o_busy
);

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_SCAN = 2'd1;
    localparam logic [1:0] W_DIV  = 2'd2;
    localparam int BIT_W = 5;

    logic [WEIGHT_W-1:0]      r_w    [MIX_COUNT];
    logic signed [STEP_W-1:0] r_step [MIX_COUNT];
    logic [RAMP_W-1:0]        r_cnt  [MIX_COUNT];
    logic [MIX_COUNT-1:0]     r_tgt;
    logic [MIX_COUNT-1:0]     r_goal;
    logic                     r_modes_set;
    logic [1:0]               r_state;
    logic [MIX_IDX_W-1:0]     r_idx;
    logic [WEIGHT_W-1:0]      r_dvd;
    logic [RAMP_W-1:0]        r_rem;
    logic [BIT_W-1:0]         r_bit;

    logic [WEIGHT_W-1:0]      w_adv  [MIX_COUNT];
    logic [MIX_COUNT-1:0]     w_goal;
    logic [RAMP_W:0]          w_trial;
    logic                     w_ge;
    logic [RAMP_W-1:0]        w_rem;
    logic [WEIGHT_W-1:0]      w_quo;
    logic signed [STEP_W-1:0] w_step;

    function automatic logic [MIX_COUNT-1:0] goal_vec(input logic [MODE_W-1:0] lo,
                                                      input logic [MODE_W-1:0] hi);
        logic [MIX_COUNT-1:0] g;
        logic [MODE_W-1:0]    l;
        logic [MODE_W-1:0]    h;
        l = (lo == MODE_BAD) ? MODE_PASS : lo;
        h = (hi == MODE_BAD) ? MODE_PASS : hi;
        g = '0;
        g[MIX_IDX_W'(l)] = 1'b1;
        g[MIX_IDX_W'(TOPOLOGY_COUNT)] = 1'b1;
        g[MIX_IDX_W'(2 * TOPOLOGY_COUNT) + MIX_IDX_W'(h)] = 1'b1;
        return g;
    endfunction

    assign o_rd_weight = r_w[i_rd_idx];
    assign o_busy      = (r_state != W_IDLE);
    assign w_goal      = goal_vec(i_req.low_mode, i_req.high_mode);

    // next weight of each section on a frame advance, clamped to 0..1.0
    always_comb begin
        logic signed [WEIGHT_W+1:0] s;
        for (int i = 0; i < MIX_COUNT; i++) begin
            s = signed'({2'b00, r_w[i]}) + (WEIGHT_W+2)'(r_step[i]);
            if (r_cnt[i] == RAMP_W'(1)) begin
                w_adv[i] = r_tgt[i] ? WEIGHT_ONE : '0;
            end else if (s < 0) begin
                w_adv[i] = '0;
            end else if (s > signed'({2'b00, WEIGHT_ONE})) begin
                w_adv[i] = WEIGHT_ONE;
            end else begin
                w_adv[i] = s[WEIGHT_W-1:0];
            end
        end
    end

    // one restoring division step
    always_comb begin
        w_trial = {r_rem, r_dvd[WEIGHT_W-1]};
        w_ge    = (w_trial >= {1'b0, i_ramp_steps});
        w_rem   = w_ge ? RAMP_W'(w_trial - {1'b0, i_ramp_steps}) : w_trial[RAMP_W-1:0];
        w_quo   = {r_dvd[WEIGHT_W-2:0], w_ge};
        w_step  = r_goal[r_idx] ? signed'({1'b0, w_quo}) : -signed'({1'b0, w_quo});
    end

    // weight state and mode sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MIX_COUNT; i++) begin
                r_w[i]    <= '0;
                r_step[i] <= '0;
                r_cnt[i]  <= '0;
            end
            r_tgt       <= '0;
            r_goal      <= '0;
            r_modes_set <= 1'b0;
            r_state     <= W_IDLE;
            r_idx       <= '0;
            r_bit       <= '0;
        end else begin
            unique case (r_state)
                W_IDLE: begin
                    if (i_req.advance) begin
                        for (int i = 0; i < MIX_COUNT; i++) begin
                            if (r_cnt[i] != '0) begin
                                r_cnt[i] <= r_cnt[i] - RAMP_W'(1);
                                r_w[i]   <= w_adv[i];
                            end
                        end
                    end else if (i_req.set_modes) begin
                        r_modes_set <= 1'b1;
                        if (!r_modes_set || i_ramp_steps == '0) begin
                            // weights jump straight to their targets
                            for (int i = 0; i < MIX_COUNT; i++) begin
                                r_w[i]    <= w_goal[i] ? WEIGHT_ONE : '0;
                                r_step[i] <= '0;
                                r_cnt[i]  <= '0;
                            end
                            r_tgt <= w_goal;
                        end else begin
                            r_goal  <= w_goal;
                            r_idx   <= '0;
                            r_state <= W_SCAN;
                        end
                    end
                end
                W_SCAN: begin
                    if (r_idx == MIX_IDX_W'(MIX_COUNT)) begin
                        r_state <= W_IDLE;
                    end else if (r_tgt[r_idx] == r_goal[r_idx]) begin
                        r_idx <= r_idx + MIX_IDX_W'(1);
                    end else begin
                        r_dvd   <= r_goal[r_idx] ? WEIGHT_ONE - r_w[r_idx] : r_w[r_idx];
                        r_rem   <= '0;
                        r_bit   <= BIT_W'(WEIGHT_W);
                        r_state <= W_DIV;
                    end
                end
                W_DIV: begin
                    r_rem <= w_rem;
                    r_dvd <= w_quo;
                    r_bit <= r_bit - BIT_W'(1);
                    if (r_bit == BIT_W'(1)) begin
                        r_step[r_idx] <= w_step;
                        r_cnt[r_idx]  <= i_ramp_steps;
                        r_tgt[r_idx]  <= r_goal[r_idx];
                        r_idx         <= r_idx + MIX_IDX_W'(1);
                        r_state       <= W_SCAN;
                    end
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/tbbe_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbe_filter
// Biquad sequencer: coefficient and delay memories around one shared
// multiplier, seven sections per sample, band mixing and output gain.
// ----------------------------------------------------------------------------
module tbbe_filter import tbbe_pkg::*; #(
    parameter int CHANNEL_SETS = DEF_CHANNEL_SETS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int COEF_BITS    = DEF_COEF_BITS,
    parameter int SET_W        = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [SET_W-1:0]              i_set,
    input  logic                          i_coef_we,
    input  logic [COEF_IDX_W-1:0]         i_coef_idx,
    input  logic signed [COEF_BITS-1:0]   i_coef_val,
    input  logic [GAIN_W-1:0]             i_gain,
    output logic [MIX_IDX_W-1:0]          o_wgt_idx,
    input  logic [WEIGHT_W-1:0]           i_wgt,
    input  logic                          i_slot_free,
    output logic                          o_busy,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int SIG_W     = SAMPLE_BITS + 8;
    localparam int ACC_W     = (SIG_W + 16 > 48) ? SIG_W + 16 : 48;
    localparam int MA_W      = (COEF_BITS > GAIN_W + 1) ? COEF_BITS : GAIN_W + 1;
    localparam int P_W       = MA_W + SIG_W;
    localparam int COEF_FRAC = COEF_BITS - 5;
    localparam int DLY_DEPTH = CHANNEL_SETS * MIX_COUNT * 2;
    localparam int DLY_AW    = $clog2(DLY_DEPTH);

    localparam logic signed [ACC_W-1:0] SIG_MAX = ACC_W'({(SIG_W-1){1'b1}});
    localparam logic signed [ACC_W-1:0] SIG_MIN = ~SIG_MAX;
    localparam logic signed [ACC_W-1:0] DLY_MAX = ACC_W'({(DELAY_W-1){1'b1}});
    localparam logic signed [ACC_W-1:0] DLY_MIN = ~DLY_MAX;
    localparam logic signed [ACC_W-1:0] SMP_MAX = ACC_W'({(SAMPLE_BITS-1){1'b1}});
    localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_C0   = 4'd1;
    localparam logic [3:0] S_C1   = 4'd2;
    localparam logic [3:0] S_C2   = 4'd3;
    localparam logic [3:0] S_C3   = 4'd4;
    localparam logic [3:0] S_C4   = 4'd5;
    localparam logic [3:0] S_C5   = 4'd6;
    localparam logic [3:0] S_C6   = 4'd7;
    localparam logic [3:0] S_C7   = 4'd8;
    localparam logic [3:0] S_G0   = 4'd9;
    localparam logic [3:0] S_G1   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    localparam logic [1:0] MUL_COEF_X = 2'd0;
    localparam logic [1:0] MUL_COEF_Y = 2'd1;
    localparam logic [1:0] MUL_WGT    = 2'd2;
    localparam logic [1:0] MUL_GAIN   = 2'd3;

    localparam logic [2:0] K_B0 = 3'd0;
    localparam logic [2:0] K_B1 = 3'd1;
    localparam logic [2:0] K_B2 = 3'd2;
    localparam logic [2:0] K_A1 = 3'd3;
    localparam logic [2:0] K_A2 = 3'd4;

    localparam logic [MIX_IDX_W-1:0] SEC_LOW_FIRST  = MIX_IDX_W'(0);
    localparam logic [MIX_IDX_W-1:0] SEC_LOW_LAST   = MIX_IDX_W'(TOPOLOGY_COUNT - 1);
    localparam logic [MIX_IDX_W-1:0] SEC_MID        = MIX_IDX_W'(TOPOLOGY_COUNT);
    localparam logic [MIX_IDX_W-1:0] SEC_HIGH_FIRST = MIX_IDX_W'(2 * TOPOLOGY_COUNT);
    localparam logic [MIX_IDX_W-1:0] SEC_HIGH_LAST  = MIX_IDX_W'(MIX_COUNT - 1);

    // memories
    logic signed [COEF_BITS-1:0] coef_mem [COEF_COUNT];
    logic signed [DELAY_W-1:0]   dly_mem  [DLY_DEPTH];
    logic [DLY_DEPTH-1:0]        r_dly_vld;
    logic signed [COEF_BITS-1:0] r_coef_q;
    logic signed [DELAY_W-1:0]   r_dly_q;
    logic                        r_dly_ok;

    // sequencer and datapath registers
    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [MIX_IDX_W-1:0]      r_sec;
    logic [SET_W-1:0]          r_set;
    logic signed [SIG_W-1:0]   r_x;
    logic signed [SIG_W-1:0]   r_y;
    logic signed [DELAY_W-1:0] r_z;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_mix;
    logic signed [ACC_W-1:0]   r_prod;
    logic signed [SAMPLE_BITS-1:0] r_res;

    logic                      w_crd;
    logic [2:0]                w_ck;
    logic [COEF_IDX_W-1:0]     w_caddr;
    logic                      w_drd;
    logic                      w_dwe;
    logic                      w_dk;
    logic [DLY_AW-1:0]         w_dbase;
    logic [DLY_AW-1:0]         w_daddr;
    logic signed [DELAY_W-1:0] w_dwdata;
    logic signed [DELAY_W-1:0] w_dly_val;
    logic [1:0]                w_msel;
    logic signed [MA_W-1:0]    w_ma;
    logic signed [SIG_W-1:0]   w_mb;
    logic signed [P_W-1:0]     w_prod;
    logic signed [P_W-1:0]     w_sh;

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v > SIG_MAX) ? SIG_MAX : ((v < SIG_MIN) ? SIG_MIN : v);
        return t[SIG_W-1:0];
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v > DLY_MAX) ? DLY_MAX : ((v < DLY_MIN) ? DLY_MIN : v);
        return t[DELAY_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v > SMP_MAX) ? SMP_MAX : ((v < SMP_MIN) ? SMP_MIN : v);
        return t[SAMPLE_BITS-1:0];
    endfunction

    assign o_busy    = (r_state != S_IDLE);
    assign o_wgt_idx = r_sec;
    assign o_result  = r_res;
    assign o_done    = (r_state == S_OUT) && i_slot_free;
    assign w_dly_val = r_dly_ok ? r_dly_q : '0;

    // memory control per sequencer step
    always_comb begin
        w_crd    = 1'b0;
        w_ck     = K_B0;
        w_drd    = 1'b0;
        w_dwe    = 1'b0;
        w_dk     = 1'b0;
        w_dwdata = sat_dly(r_acc - r_prod);
        w_msel   = MUL_COEF_X;
        unique case (r_state)
            S_C0: begin
                w_crd = 1'b1;
                w_ck  = K_B0;
                w_drd = 1'b1;
            end
            S_C1: begin
                w_crd = 1'b1;
                w_ck  = K_B1;
                w_drd = 1'b1;
                w_dk  = 1'b1;
            end
            S_C2: begin
                w_crd = 1'b1;
                w_ck  = K_A1;
            end
            S_C3: begin
                w_crd  = 1'b1;
                w_ck   = K_B2;
                w_msel = MUL_COEF_Y;
            end
            S_C4: begin
                w_crd = 1'b1;
                w_ck  = K_A2;
                w_dwe = 1'b1;
            end
            S_C5: begin
                w_msel = MUL_COEF_Y;
            end
            S_C6: begin
                w_dwe  = 1'b1;
                w_dk   = 1'b1;
                w_msel = MUL_WGT;
            end
            S_G0: begin
                w_msel = MUL_GAIN;
            end
            default: begin
                w_crd = 1'b0;
            end
        endcase
        w_caddr = COEF_IDX_W'(r_sec) * COEF_IDX_W'(COEF_TAPS) + COEF_IDX_W'(w_ck);
        w_dbase = DLY_AW'(r_set) * DLY_AW'(MIX_COUNT * 2) + DLY_AW'({r_sec, 1'b0});
        w_daddr = w_dbase + DLY_AW'(w_dk);
    end

    // shared multiplier with floor shift to the signal fraction
    always_comb begin
        case (w_msel)
            MUL_COEF_X: begin
                w_ma = MA_W'(r_coef_q);
                w_mb = r_x;
            end
            MUL_COEF_Y: begin
                w_ma = MA_W'(r_coef_q);
                w_mb = r_y;
            end
            MUL_WGT: begin
                w_ma = MA_W'({1'b0, i_wgt});
                w_mb = r_y;
            end
            default: begin
                w_ma = MA_W'({1'b0, i_gain});
                w_mb = r_x;
            end
        endcase
        w_prod = w_ma * w_mb;
        case (w_msel)
            MUL_WGT:  w_sh = w_prod >>> WEIGHT_FRAC;
            MUL_GAIN: w_sh = w_prod >>> GAIN_FRAC;
            default:  w_sh = w_prod >>> COEF_FRAC;
        endcase
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (i_coef_we && i_coef_idx < COEF_IDX_W'(COEF_COUNT)) begin
            coef_mem[i_coef_idx] <= i_coef_val;
        end
        if (w_crd) begin
            r_coef_q <= coef_mem[w_caddr];
        end
    end

    // delay memory
    always_ff @(posedge i_clk) begin
        if (w_dwe) begin
            dly_mem[w_daddr] <= w_dwdata;
        end
        if (w_drd) begin
            r_dly_q <= dly_mem[w_daddr];
        end
    end

    // delay valid bits, an unwritten word reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_vld <= '0;
            r_dly_ok  <= 1'b0;
        end else begin
            if (w_dwe) begin
                r_dly_vld[w_daddr] <= 1'b1;
            end
            if (w_drd) begin
                r_dly_ok <= r_dly_vld[w_daddr];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: n_state = i_start ? S_C0 : S_IDLE;
            S_C0:   n_state = S_C1;
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_C3;
            S_C3:   n_state = S_C4;
            S_C4:   n_state = S_C5;
            S_C5:   n_state = S_C6;
            S_C6:   n_state = S_C7;
            S_C7:   n_state = (r_sec == SEC_HIGH_LAST) ? S_G0 : S_C0;
            S_G0:   n_state = S_G1;
            S_G1:   n_state = S_OUT;
            S_OUT:  n_state = i_slot_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_sh[ACC_W-1:0];
        case (r_state)
            S_IDLE: begin
                r_x   <= SIG_W'(i_sample);
                r_set <= i_set;
                r_sec <= SEC_LOW_FIRST;
            end
            S_C1: begin
                r_z <= w_dly_val;
            end
            S_C2: begin
                r_y <= sat_sig(r_prod + ACC_W'(r_z));
                r_z <= w_dly_val;
            end
            S_C3: begin
                r_acc <= r_prod + ACC_W'(r_z);
            end
            S_C5: begin
                r_acc <= r_prod;
            end
            S_C7: begin
                // band mixing and hand-over to the next section
                if (r_sec == SEC_MID) begin
                    r_x   <= r_y;
                    r_sec <= SEC_HIGH_FIRST;
                end else begin
                    if (r_sec == SEC_LOW_FIRST || r_sec == SEC_HIGH_FIRST) begin
                        r_mix <= r_prod;
                    end else if (r_sec == SEC_LOW_LAST || r_sec == SEC_HIGH_LAST) begin
                        r_x <= sat_sig(r_mix + r_prod);
                    end else begin
                        r_mix <= r_mix + r_prod;
                    end
                    r_sec <= r_sec + MIX_IDX_W'(1);
                end
            end
            S_G1: begin
                r_res <= sat_smp(r_prod);
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

endmodule

>>> sv/three_band_biquad_equalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_band_biquad_equalizer
// Three-band biquad equaliser with crossfaded outer band topologies.
// ----------------------------------------------------------------------------
// A sample request runs seven biquad sections on the one shared multiplier
// and the single read port of the coefficient memory, then output gain and
// saturation, and then waits in the output state until the output register
// is free to be loaded. The input is not ready again until that load, so a
// new sample is not accepted before the last one is through. A coefficient
// write gives no result. A mode request keeps the input busy while the nine
// weights are scanned, and while the bit-serial ramp divider runs for each
// weight whose target changes (at most four); the first mode request after
// reset, or one with a zero ramp length, sets the weights straight to their
// targets and does not make the input busy. Delay words read as zero after
// reset through their valid bits, with no clearing pass. One request is
// worked on at a time, and a new one may be accepted while a finished result
// still waits in the output register.
module three_band_biquad_equalizer import tbbe_pkg::*; #(
    parameter int CHANNEL_SETS = DEF_CHANNEL_SETS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int COEF_BITS    = DEF_COEF_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_req_type,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [CH_W-1:0]               i_channel,
    input  logic                          i_frame_start,
    input  logic [COEF_IDX_W-1:0]         i_coef_index,
    input  logic signed [COEF_BITS-1:0]   i_coef_value,
    input  logic [MODE_W-1:0]             i_low_mode,
    input  logic [MODE_W-1:0]             i_high_mode,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic [CH_W-1:0]               o_out_channel,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [GAIN_W-1:0]             i_cfg_wdata
);

    localparam int SET_W = (CHANNEL_SETS > 1) ? $clog2(CHANNEL_SETS) : 1;

    logic [RAMP_W-1:0]        r_ramp;
    logic [GAIN_W-1:0]        r_gain;
    logic [CH_W-1:0]          r_ch;
    logic                     r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_smp;
    logic [CH_W-1:0]          r_out_ch;

    logic                     w_accept;
    logic                     w_sample;
    logic [SET_W-1:0]         w_set;
    logic                     w_slot_free;
    logic                     w_flt_busy;
    logic                     w_flt_done;
    logic signed [SAMPLE_BITS-1:0] w_flt_res;
    logic                     w_wgt_busy;
    logic [MIX_IDX_W-1:0]     w_wgt_idx;
    logic [WEIGHT_W-1:0]      w_wgt;
    t_wgt_req                 w_wreq;

    // request decode
    assign o_ready     = !w_flt_busy && !w_wgt_busy;
    assign w_accept    = i_valid && o_ready;
    assign w_sample    = w_accept && (i_req_type == REQ_SAMPLE);
    assign w_slot_free = !r_out_vld || i_ready;
    assign w_set       = (i_channel >= CH_W'(CHANNEL_SETS - 1)) ? SET_W'(CHANNEL_SETS - 1)
                                                                 : SET_W'(i_channel);

    always_comb begin
        w_wreq.advance   = w_sample && i_frame_start;
        w_wreq.set_modes = w_accept && (i_req_type == REQ_MODE);
        w_wreq.low_mode  = i_low_mode;
        w_wreq.high_mode = i_high_mode;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp <= RAMP_RESET;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RAMP_STEPS:  r_ramp <= i_cfg_wdata[RAMP_W-1:0];
                CFG_OUTPUT_GAIN: r_gain <= i_cfg_wdata;
                default:         r_gain <= r_gain;
            endcase
        end
    end

    // channel of the sample in flight
    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_ch <= i_channel;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_flt_done) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flt_done) begin
            r_out_smp <= w_flt_res;
            r_out_ch  <= r_ch;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_sample_out  = r_out_smp;
    assign o_out_channel = r_out_ch;

    tbbe_weights u_weights (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_wreq),
        .i_ramp_steps (r_ramp),
        .i_rd_idx     (w_wgt_idx),
        .o_rd_weight  (w_wgt),
        .o_busy       (w_wgt_busy)
    );

    tbbe_filter #(
        .CHANNEL_SETS (CHANNEL_SETS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COEF_BITS    (COEF_BITS),
        .SET_W        (SET_W)
    ) u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_sample),
        .i_sample    (i_sample_in),
        .i_set       (w_set),
        .i_coef_we   (w_accept && (i_req_type == REQ_COEF)),
        .i_coef_idx  (i_coef_index),
        .i_coef_val  (i_coef_value),
        .i_gain      (r_gain),
        .o_wgt_idx   (w_wgt_idx),
        .i_wgt       (w_wgt),
        .i_slot_free (w_slot_free),
        .o_busy      (w_flt_busy),
        .o_done      (w_flt_done),
        .o_result    (w_flt_res)
    );

endmodule
